[hdl/pva_pkg.sv]
// Shared types and constants of the polyphonic voice allocator.
package pva_pkg;

  localparam int unsigned VoiceCountDefault = 64;
  localparam int unsigned VoiceW            = 6;
  localparam int unsigned MaskW             = 64;
  localparam int unsigned ChanW             = 4;
  localparam int unsigned PitchW            = 7;
  localparam int unsigned VelW              = 7;
  localparam int unsigned InDataW           = 32;
  localparam int unsigned OutDataW          = 80;

  typedef enum logic [1:0] {
    MODE_NOTE_ON    = 2'd0,
    MODE_NOTE_OFF   = 2'd1,
    MODE_ALL_OFF    = 2'd2,
    MODE_VOICE_DONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_IGNORED    = 3'd0,
    ACT_RETRIGGER  = 3'd1,
    ACT_FREE       = 3'd2,
    ACT_STEAL_REL  = 3'd3,
    ACT_STEAL_ZERO = 3'd4,
    ACT_RELEASED   = 3'd5,
    ACT_FREED      = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              en;
    mode_e             mode;
    logic [ChanW-1:0]  channel;
    logic [PitchW-1:0] pitch;
    logic [VelW-1:0]   velocity;
    logic [VoiceW-1:0] voice_index;
  } cmd_t;

endpackage

[hdl/polyphonic_voice_allocator.sv]
// Voice table with note-on allocation, release and voice stealing.
//
// Events enter on the s_axis channel and each one gives exactly one result
// transaction on the m_axis channel. A one-bit enable register is written over
// the cfg channel, which is always ready; it should only change while idle.
// Note-on, note-off and all-notes-off events scan the whole voice table through
// one channel and pitch memory port and one comparator, one voice per cycle, so
// such an event gives its result after the scan and the finish state, and the
// next event is accepted only after the block is back in the idle state.
// Voice-finished events and events seen while disabled skip the scan and give
// their result from the finish state.
// The block accepts one event at a time and is ready only while idle.
// The result sits in an output register; a stalled receiver holds it there, and
// the block still accepts and works on the next event, waiting only when it
// must hand over a new result while the old one is not yet taken.
// Reset clears every active and releasing flag, the enable register and the
// output valid at once; no clearing pass runs, and the channel and pitch memory
// is left as it is, since it is read only for active voices.
module polyphonic_voice_allocator #(
  parameter int unsigned VOICE_COUNT = pva_pkg::VoiceCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,     // engine_enabled
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // mode[1:0], channel[5:2], pitch[12:6], velocity[19:13], voice_index[25:20]
  input  logic [pva_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // action[2:0], chosen_voice[8:3], start_velocity[15:9], affected_mask[79:16]
  output logic [pva_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IW  = $clog2(VOICE_COUNT);
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned VIW = pva_pkg::VoiceW + 1;
  localparam int unsigned EW  = pva_pkg::ChanW + pva_pkg::PitchW;

  pva_pkg::state_e state_q, state_d;
  pva_pkg::cmd_t   cmd_q;
  logic            en_q;

  logic [VOICE_COUNT-1:0] active_q;
  logic [VOICE_COUNT-1:0] releasing_q;
  logic [EW-1:0]          entry_mem [VOICE_COUNT];
  logic [EW-1:0]          rdata_q;

  logic [CW-1:0]          idx_q;
  logic                   cmp_vld_q;
  logic [IW-1:0]          cmp_idx_q;
  logic                   match_found_q, free_found_q, rel_found_q;
  logic [IW-1:0]          match_idx_q, free_idx_q, rel_idx_q;
  logic [VOICE_COUNT-1:0] mask_q;

  logic                   out_vld_q;
  pva_pkg::action_e       out_action_q;
  logic [pva_pkg::VoiceW-1:0] out_voice_q;
  logic [pva_pkg::VelW-1:0]   out_vel_q;
  logic [pva_pkg::MaskW-1:0]  out_mask_q;

  logic                   in_fire;
  logic                   scan_issue;
  logic                   scan_last;
  logic                   fin_fire;
  logic                   direct;
  logic                   held;
  logic                   hit;
  logic                   vi_ok;
  logic                   start_voice;
  logic                   free_voice;
  logic [IW-1:0]          pick;
  logic [IW-1:0]          vi_idx;
  logic [VOICE_COUNT-1:0] pick_onehot;
  logic [VOICE_COUNT-1:0] vi_onehot;

  pva_pkg::action_e           res_action;
  logic [pva_pkg::VoiceW-1:0] res_voice;
  logic [pva_pkg::VelW-1:0]   res_vel;
  logic [pva_pkg::MaskW-1:0]  res_mask;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign direct      = !en_q || (pva_pkg::mode_e'(s_axis_tdata[1:0]) ==
                                 pva_pkg::MODE_VOICE_DONE);
  assign scan_last   = (idx_q == CW'(VOICE_COUNT)) && cmp_vld_q;

  always_comb begin
    s_axis_tready = 1'b0;
    scan_issue    = 1'b0;
    fin_fire      = 1'b0;
    case (state_q)
      pva_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      pva_pkg::ST_SCAN: begin
        scan_issue = idx_q < CW'(VOICE_COUNT);
      end
      pva_pkg::ST_FIN: begin
        fin_fire = !out_vld_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pva_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = direct ? pva_pkg::ST_FIN : pva_pkg::ST_SCAN;
        end
      end
      pva_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = pva_pkg::ST_FIN;
        end
      end
      pva_pkg::ST_FIN: begin
        if (fin_fire) begin
          state_d = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pva_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::ST_IDLE;
      en_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.en          <= en_q;
      cmd_q.mode        <= pva_pkg::mode_e'(s_axis_tdata[1:0]);
      cmd_q.channel     <= s_axis_tdata[5:2];
      cmd_q.pitch       <= s_axis_tdata[12:6];
      cmd_q.velocity    <= s_axis_tdata[19:13];
      cmd_q.voice_index <= s_axis_tdata[25:20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      rdata_q <= entry_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire && start_voice) begin
      entry_mem[pick] <= {cmd_q.channel, cmd_q.pitch};
    end
  end

  assign held = active_q[cmp_idx_q] && !releasing_q[cmp_idx_q] &&
                (rdata_q == {cmd_q.channel, cmd_q.pitch});
  assign hit  = cmp_vld_q && cmd_q.mode != pva_pkg::MODE_NOTE_ON &&
                ((cmd_q.mode == pva_pkg::MODE_NOTE_OFF) ? held : active_q[cmp_idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      rel_found_q   <= 1'b0;
      match_idx_q   <= '0;
      free_idx_q    <= '0;
      rel_idx_q     <= '0;
      mask_q        <= '0;
    end else if (in_fire) begin
      idx_q         <= '0;
      cmp_vld_q     <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      rel_found_q   <= 1'b0;
      mask_q        <= '0;
    end else begin
      cmp_vld_q <= scan_issue;
      if (scan_issue) begin
        idx_q     <= idx_q + CW'(1);
        cmp_idx_q <= idx_q[IW-1:0];
      end
      if (cmp_vld_q && cmd_q.mode == pva_pkg::MODE_NOTE_ON) begin
        if (held && !match_found_q) begin
          match_found_q <= 1'b1;
          match_idx_q   <= cmp_idx_q;
        end
        if (!active_q[cmp_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
        if (releasing_q[cmp_idx_q] && !rel_found_q) begin
          rel_found_q <= 1'b1;
          rel_idx_q   <= cmp_idx_q;
        end
      end
      if (hit) begin
        mask_q[cmp_idx_q] <= 1'b1;
      end
    end
  end

  assign vi_idx      = cmd_q.voice_index[IW-1:0];
  assign vi_ok       = VIW'(cmd_q.voice_index) < VIW'(VOICE_COUNT);
  assign pick_onehot = VOICE_COUNT'(1) << pick;
  assign vi_onehot   = VOICE_COUNT'(1) << vi_idx;

  always_comb begin
    res_action  = pva_pkg::ACT_IGNORED;
    res_voice   = '0;
    res_vel     = '0;
    res_mask    = '0;
    start_voice = 1'b0;
    free_voice  = 1'b0;
    pick        = '0;
    if (cmd_q.en) begin
      case (cmd_q.mode)
        pva_pkg::MODE_NOTE_ON: begin
          if (match_found_q) begin
            res_action = pva_pkg::ACT_RETRIGGER;
            pick       = match_idx_q;
          end else if (free_found_q) begin
            res_action = pva_pkg::ACT_FREE;
            pick       = free_idx_q;
          end else if (rel_found_q) begin
            res_action = pva_pkg::ACT_STEAL_REL;
            pick       = rel_idx_q;
          end else begin
            res_action = pva_pkg::ACT_STEAL_ZERO;
          end
          start_voice = !match_found_q;
          res_voice   = pva_pkg::VoiceW'(pick);
          res_vel     = cmd_q.velocity;
          res_mask    = pva_pkg::MaskW'(pick_onehot);
        end
        pva_pkg::MODE_NOTE_OFF, pva_pkg::MODE_ALL_OFF: begin
          if (mask_q != '0) begin
            res_action = pva_pkg::ACT_RELEASED;
            res_mask   = pva_pkg::MaskW'(mask_q);
          end
        end
        pva_pkg::MODE_VOICE_DONE: begin
          if (vi_ok && active_q[vi_idx]) begin
            res_action = pva_pkg::ACT_FREED;
            res_voice  = cmd_q.voice_index;
            res_mask   = pva_pkg::MaskW'(vi_onehot);
            free_voice = 1'b1;
          end
        end
        default: begin
          res_action = pva_pkg::ACT_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      releasing_q <= '0;
    end else begin
      if (hit) begin
        releasing_q[cmp_idx_q] <= 1'b1;
      end
      if (fin_fire && start_voice) begin
        active_q[pick]    <= 1'b1;
        releasing_q[pick] <= 1'b0;
      end
      if (fin_fire && free_voice) begin
        active_q[vi_idx]    <= 1'b0;
        releasing_q[vi_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_action_q <= res_action;
      out_voice_q  <= res_voice;
      out_vel_q    <= res_vel;
      out_mask_q   <= res_mask;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_mask_q, out_vel_q, out_voice_q, out_action_q};

`ifndef ASSERT_OFF
  a_release_needs_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (releasing_q & ~active_q) == '0)
    else $error("A voice is releasing without being active.");

  a_single_voice_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_action_q == pva_pkg::ACT_RETRIGGER ||
                  out_action_q == pva_pkg::ACT_FREE ||
                  out_action_q == pva_pkg::ACT_STEAL_REL ||
                  out_action_q == pva_pkg::ACT_STEAL_ZERO ||
                  out_action_q == pva_pkg::ACT_FREED) |-> $onehot(out_mask_q))
    else $error("A single-voice result does not mark exactly one voice.");

  a_compare_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == pva_pkg::ST_SCAN)
    else $error("A table compare is pending outside the scan.");

  a_start_sets_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire && start_voice |=> active_q[$past(pick)])
    else $error("A started voice is not active afterwards.");
`endif

endmodule

[verif/polyphonic_voice_allocator_tb.sv]
// Self-checking testbench for the polyphonic voice allocator with random stalls on both streams.
module polyphonic_voice_allocator_tb;

  localparam int Voices = pva_pkg::VoiceCountDefault;

  typedef struct {
    pva_pkg::action_e           action;
    logic [pva_pkg::VoiceW-1:0] voice;
    logic [pva_pkg::VelW-1:0]   vel;
    logic [pva_pkg::MaskW-1:0]  mask;
  } outcome_t;

  typedef struct {
    bit                          en;
    logic [pva_pkg::InDataW-1:0] data;
    bit                          typed;
    outcome_t                    want;
  } row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic                         cfg_data_i = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [pva_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [pva_pkg::OutDataW-1:0] m_axis_tdata;

  bit                          engine_on;
  bit                          voice_on [Voices];
  bit                          voice_rel [Voices];
  logic [pva_pkg::ChanW-1:0]   voice_chan [Voices];
  logic [pva_pkg::PitchW-1:0]  voice_note [Voices];

  outcome_t pending_outcomes[$];
  row_t     script[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       mismatch_count;
  int       events_sent;
  int       seen_by_action [8];

  polyphonic_voice_allocator #(
    .VOICE_COUNT(Voices)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8000000;
    $display("[polyphonic_voice_allocator] ERROR");
    $finish;
  end

  function automatic logic [pva_pkg::InDataW-1:0] pack_event(
      pva_pkg::mode_e m, logic [pva_pkg::ChanW-1:0] ch, logic [pva_pkg::PitchW-1:0] p,
      logic [pva_pkg::VelW-1:0] vel, logic [pva_pkg::VoiceW-1:0] vi);
    return {6'd0, vi, vel, p, ch, m};
  endfunction

  function automatic bit is_held(int v, logic [pva_pkg::ChanW-1:0] ch,
                                 logic [pva_pkg::PitchW-1:0] p);
    return voice_on[v] && !voice_rel[v] && voice_chan[v] == ch && voice_note[v] == p;
  endfunction

  function automatic outcome_t compute_allocation(logic [pva_pkg::InDataW-1:0] d);
    outcome_t                   o;
    pva_pkg::mode_e             m;
    logic [pva_pkg::ChanW-1:0]  ch;
    logic [pva_pkg::PitchW-1:0] p;
    logic [pva_pkg::VelW-1:0]   vel;
    logic [pva_pkg::VoiceW-1:0] vi;
    int                         pick;
    bit                         found;
    m = pva_pkg::mode_e'(d[1:0]);
    ch = d[5:2];
    p = d[12:6];
    vel = d[19:13];
    vi = d[25:20];
    o.action = pva_pkg::ACT_IGNORED;
    o.voice = '0;
    o.vel = '0;
    o.mask = '0;
    if (!engine_on) return o;
    case (m)
      pva_pkg::MODE_NOTE_ON: begin
        for (int v = 0; v < Voices; v++) begin
          if (is_held(v, ch, p)) begin
            o.action = pva_pkg::ACT_RETRIGGER;
            o.voice = pva_pkg::VoiceW'(v);
            o.vel = vel;
            o.mask = 64'd1 << v;
            return o;
          end
        end
        pick = 0;
        found = 1'b0;
        o.action = pva_pkg::ACT_STEAL_ZERO;
        for (int v = 0; v < Voices && !found; v++) begin
          if (!voice_on[v]) begin
            pick = v;
            found = 1'b1;
            o.action = pva_pkg::ACT_FREE;
          end
        end
        for (int v = 0; v < Voices && !found; v++) begin
          if (voice_rel[v]) begin
            pick = v;
            found = 1'b1;
            o.action = pva_pkg::ACT_STEAL_REL;
          end
        end
        voice_on[pick] = 1'b1;
        voice_rel[pick] = 1'b0;
        voice_chan[pick] = ch;
        voice_note[pick] = p;
        o.voice = pva_pkg::VoiceW'(pick);
        o.vel = vel;
        o.mask = 64'd1 << pick;
      end
      pva_pkg::MODE_NOTE_OFF, pva_pkg::MODE_ALL_OFF: begin
        for (int v = 0; v < Voices; v++) begin
          if ((m == pva_pkg::MODE_NOTE_OFF) ? is_held(v, ch, p) : voice_on[v]) begin
            voice_rel[v] = 1'b1;
            o.mask[v] = 1'b1;
          end
        end
        if (o.mask != '0) o.action = pva_pkg::ACT_RELEASED;
      end
      default: begin
        if (int'(vi) < Voices && voice_on[vi]) begin
          voice_on[vi] = 1'b0;
          voice_rel[vi] = 1'b0;
          o.action = pva_pkg::ACT_FREED;
          o.voice = vi;
          o.mask = 64'd1 << vi;
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [pva_pkg::InDataW-1:0] random_event();
    int                         held[$];
    int                         live[$];
    int                         pick;
    int                         v;
    pva_pkg::mode_e             m;
    logic [pva_pkg::ChanW-1:0]  ch;
    logic [pva_pkg::PitchW-1:0] p;
    logic [pva_pkg::VelW-1:0]   vel;
    logic [pva_pkg::VoiceW-1:0] vi;
    ch = pva_pkg::ChanW'($urandom);
    p = pva_pkg::PitchW'($urandom);
    vel = pva_pkg::VelW'($urandom);
    vi = pva_pkg::VoiceW'($urandom);
    for (int i = 0; i < Voices; i++) begin
      if (voice_on[i]) live.push_back(i);
      if (voice_on[i] && !voice_rel[i]) held.push_back(i);
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      m = pva_pkg::MODE_NOTE_ON;
      if (held.size() != 0 && $urandom_range(3) == 0) begin
        v = held[$urandom_range(held.size() - 1)];
        ch = voice_chan[v];
        p = voice_note[v];
      end
    end else if (pick < 68) begin
      m = pva_pkg::MODE_NOTE_OFF;
      if (held.size() != 0 && $urandom_range(4) != 0) begin
        v = held[$urandom_range(held.size() - 1)];
        ch = voice_chan[v];
        p = voice_note[v];
      end
    end else if (pick < 71) begin
      m = pva_pkg::MODE_ALL_OFF;
    end else if (pick < 89) begin
      m = pva_pkg::MODE_VOICE_DONE;
      if (live.size() != 0 && $urandom_range(4) != 0) begin
        vi = pva_pkg::VoiceW'(live[$urandom_range(live.size() - 1)]);
      end
    end else begin
      m = pva_pkg::mode_e'($urandom_range(3));
    end
    return pack_event(m, ch, p, vel, vi);
  endfunction

  task automatic send_event(input logic [pva_pkg::InDataW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    events_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_enable(input bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    engine_on = value;
  endtask

  task automatic run_random(input int count, input int sidle, input int ridle);
    logic [pva_pkg::InDataW-1:0] d;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (count) begin
      d = random_event();
      send_event(d);
      pending_outcomes.push_back(compute_allocation(d));
    end
  endtask

  function automatic void add_row(bit en, pva_pkg::mode_e m, int ch, int p, int vel, int vi,
                                  bit typed, pva_pkg::action_e a, int voice, int svel,
                                  logic [pva_pkg::MaskW-1:0] mask);
    row_t r;
    r.en = en;
    r.data = pack_event(m, pva_pkg::ChanW'(ch), pva_pkg::PitchW'(p), pva_pkg::VelW'(vel),
                        pva_pkg::VoiceW'(vi));
    r.typed = typed;
    r.want.action = a;
    r.want.voice = pva_pkg::VoiceW'(voice);
    r.want.vel = pva_pkg::VelW'(svel);
    r.want.mask = mask;
    script.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.action = pva_pkg::action_e'(m_axis_tdata[2:0]);
        got.voice = m_axis_tdata[8:3];
        got.vel = m_axis_tdata[15:9];
        got.mask = m_axis_tdata[79:16];
        seen_by_action[m_axis_tdata[2:0]]++;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, actual action %0d voice %0d vel %0d mask %h",
                   $time, got.action, got.voice, got.vel, got.mask);
          mismatch_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.action !== want.action || got.voice !== want.voice ||
              got.vel !== want.vel || got.mask !== want.mask) begin
            $display("%0t: expected action %0d voice %0d vel %0d mask %h", $time,
                     want.action, want.voice, want.vel, want.mask);
            $display("%0t: actual   action %0d voice %0d vel %0d mask %h", $time,
                     got.action, got.voice, got.vel, got.mask);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    outcome_t predicted;
    engine_on = 1'b0;
    for (int v = 0; v < Voices; v++) begin
      voice_on[v] = 1'b0;
      voice_rel[v] = 1'b0;
      voice_chan[v] = '0;
      voice_note[v] = '0;
    end
    send_idle_pct = 23;
    recv_idle_pct = 66;

    add_row(0, pva_pkg::MODE_NOTE_ON, 15, 127, 127, 63, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(0, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 0, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(0, pva_pkg::MODE_ALL_OFF, 15, 127, 127, 63, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_OFF, 0, 0, 0, 0, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_ALL_OFF, 0, 0, 0, 0, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 0, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_ON, 0, 0, 0, 0, 1, pva_pkg::ACT_FREE, 0, 0, 64'h1);
    add_row(1, pva_pkg::MODE_NOTE_ON, 15, 127, 127, 63, 1, pva_pkg::ACT_FREE, 1, 127, 64'h2);
    add_row(1, pva_pkg::MODE_NOTE_ON, 15, 127, 64, 0, 1, pva_pkg::ACT_RETRIGGER, 1, 64, 64'h2);
    add_row(1, pva_pkg::MODE_NOTE_ON, 3, 60, 100, 5, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_OFF, 15, 127, 9, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_OFF, 15, 127, 9, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_ON, 15, 127, 1, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_ALL_OFF, 7, 7, 7, 7, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 1, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 1, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 63, 1, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_ON, 5, 42, 33, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 0, 0, 0, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_OFF, 5, 42, 127, 63, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_VOICE_DONE, 15, 127, 127, 2, 0, pva_pkg::ACT_IGNORED, 0, 0,
            64'h0);
    add_row(1, pva_pkg::MODE_NOTE_ON, 8, 1, 127, 63, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);
    add_row(1, pva_pkg::MODE_NOTE_OFF, 8, 1, 0, 0, 0, pva_pkg::ACT_IGNORED, 0, 0, 64'h0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_enable(1'b0);

    foreach (script[i]) begin
      if (script[i].en != engine_on) begin
        drain();
        write_enable(script[i].en);
      end
      send_event(script[i].data);
      predicted = compute_allocation(script[i].data);
      pending_outcomes.push_back(script[i].typed ? script[i].want : predicted);
    end

    run_random(170, 23, 66);
    drain();
    write_enable(1'b0);
    run_random(12, 23, 66);
    drain();
    write_enable(1'b1);
    run_random(170, 66, 23);
    run_random(160, 0, 0);
    drain();
    repeat (Voices + 3) @(posedge clk_i);

    $display("Covered %0d events: %0d ignored, %0d retriggers, %0d free picks,",
             events_sent, seen_by_action[pva_pkg::ACT_IGNORED],
             seen_by_action[pva_pkg::ACT_RETRIGGER], seen_by_action[pva_pkg::ACT_FREE]);
    $display("%0d releasing steals, %0d voice-zero steals, %0d releases, %0d frees.",
             seen_by_action[pva_pkg::ACT_STEAL_REL], seen_by_action[pva_pkg::ACT_STEAL_ZERO],
             seen_by_action[pva_pkg::ACT_RELEASED], seen_by_action[pva_pkg::ACT_FREED]);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[polyphonic_voice_allocator] OK");
    end else begin
      $display("[polyphonic_voice_allocator] ERROR");
    end
    $finish;
  end

endmodule
